// ----- hw/rtl/pfb_pkg.sv -----
package pfb_pkg;

  // Default panel geometry
  localparam int unsigned PanelColumnsDefault = 84;
  localparam int unsigned PanelRowsDefault    = 48;

  // Controller command codes and the bit-in-page mask
  localparam logic [7:0] CMD_PAGE    = 8'h40;
  localparam logic [7:0] CMD_COLUMN  = 8'h80;
  localparam logic [2:0] BIT_IN_PAGE = 3'd7;

  // Pixel queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic [6:0] column;
    logic [2:0] page;
    logic [2:0] bit_sel;
    logic       colour;
  } pfb_entry_t;

  typedef struct packed {
    logic clearing;
  } pfb_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAGE,
    ST_COLUMN,
    ST_DATA
  } pfb_state_e;

endpackage

// ----- hw/rtl/pfb_ram.sv -----
module pfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 504
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pfb_front.sv -----
module pfb_front #(
  parameter int unsigned PANEL_COLUMNS = pfb_pkg::PanelColumnsDefault,
  parameter int unsigned PANEL_ROWS    = pfb_pkg::PanelRowsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [6:0]          column_i,
  input  logic [5:0]          row_i,
  input  logic                colour_i,
  input  logic                q_full_i,
  input  pfb_pkg::pfb_status_t status_i,
  output logic                push_o,
  output pfb_pkg::pfb_entry_t push_entry_o
);

  logic on_panel;
  logic busy_q;

  // Hold off new pixels while the store is being cleared
  assign in_ready_o = !q_full_i && !status_i.clearing && !busy_q;

  assign on_panel = ({1'b0, column_i} < 8'(PANEL_COLUMNS)) &&
                    ({1'b0, row_i} < 7'(PANEL_ROWS));

  // Drop off-panel requests: accept them but push nothing
  assign push_o = in_valid_i && in_ready_o && on_panel;

  always_comb begin
    push_entry_o.column  = column_i;
    push_entry_o.page    = row_i[5:3];
    push_entry_o.bit_sel = row_i[2:0] & pfb_pkg::BIT_IN_PAGE;
    push_entry_o.colour  = colour_i;
  end

  // Hold the front closed in the cycle reset is released
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/pfb_queue.sv -----
module pfb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pfb_pkg::pfb_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output pfb_pkg::pfb_entry_t head_o
);

  pfb_pkg::pfb_entry_t           mem_q [pfb_pkg::QueueDepth];
  logic [pfb_pkg::QueuePtrW:0]   wr_ptr_q, wr_ptr_d;
  logic [pfb_pkg::QueuePtrW:0]   rd_ptr_q, rd_ptr_d;

  assign valid_o = (wr_ptr_q != rd_ptr_q);
  assign full_o  = (wr_ptr_q[pfb_pkg::QueuePtrW] != rd_ptr_q[pfb_pkg::QueuePtrW]) &&
                   (wr_ptr_q[pfb_pkg::QueuePtrW-1:0] == rd_ptr_q[pfb_pkg::QueuePtrW-1:0]);
  assign head_o  = mem_q[rd_ptr_q[pfb_pkg::QueuePtrW-1:0]];

  assign wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q[pfb_pkg::QueuePtrW-1:0]] <= push_entry_i;
    end
  end

endmodule

// ----- hw/rtl/pfb_back.sv -----
module pfb_back #(
  parameter int unsigned PANEL_COLUMNS = pfb_pkg::PanelColumnsDefault,
  parameter int unsigned PANEL_ROWS    = pfb_pkg::PanelRowsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  pfb_pkg::pfb_entry_t  q_head_i,
  output logic                 pop_o,
  output pfb_pkg::pfb_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 is_data_o,
  output logic                 last_o
);

  localparam int unsigned PageCount  = (PANEL_ROWS + 7) / 8;
  localparam int unsigned StoreDepth = PageCount * PANEL_COLUMNS;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  pfb_pkg::pfb_state_e state_q, state_d;
  pfb_pkg::pfb_entry_t cur_q, cur_d;
  logic [AddrW-1:0]    idx_q, idx_d;
  logic [AddrW-1:0]    clr_q, clr_d;
  logic [7:0]          val_q, val_d;
  logic [AddrW-1:0]    head_idx;
  logic [7:0]          rdata;
  logic [7:0]          mask;
  logic [7:0]          new_val;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [7:0]          ram_wdata;
  logic                xfer;

  assign xfer     = out_valid_o && out_ready_i;
  assign head_idx = AddrW'(q_head_i.page) * AddrW'(PANEL_COLUMNS) + AddrW'(q_head_i.column);
  assign mask     = 8'(1) << cur_q.bit_sel;
  assign new_val  = cur_q.colour ? (rdata | mask) : (rdata & ~mask);

  // Next pixel enters when idle, or straight after the data byte goes out
  assign pop_o = q_valid_i &&
                 ((state_q == pfb_pkg::ST_IDLE) || ((state_q == pfb_pkg::ST_DATA) && xfer));

  pfb_ram #(
    .Width(8),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (pop_o),
    .raddr_i(head_idx),
    .rdata_o(rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfb_pkg::ST_CLEAR: begin
        if (clr_q == AddrW'(StoreDepth - 1)) begin
          state_d = pfb_pkg::ST_IDLE;
        end
      end
      pfb_pkg::ST_IDLE: begin
        if (pop_o) begin
          state_d = pfb_pkg::ST_PAGE;
        end
      end
      pfb_pkg::ST_PAGE: begin
        if (xfer) begin
          state_d = pfb_pkg::ST_COLUMN;
        end
      end
      pfb_pkg::ST_COLUMN: begin
        if (xfer) begin
          state_d = pfb_pkg::ST_DATA;
        end
      end
      pfb_pkg::ST_DATA: begin
        if (xfer) begin
          state_d = pop_o ? pfb_pkg::ST_PAGE : pfb_pkg::ST_IDLE;
        end
      end
      default: state_d = pfb_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    out_valid_o = 1'b0;
    out_byte_o  = '0;
    is_data_o   = 1'b0;
    last_o      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = new_val;
    clr_d       = clr_q;
    val_d       = val_q;
    cur_d       = pop_o ? q_head_i : cur_q;
    idx_d       = pop_o ? head_idx : idx_q;
    status_o.clearing = 1'b0;
    case (state_q)
      pfb_pkg::ST_CLEAR: begin
        status_o.clearing = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      pfb_pkg::ST_IDLE: begin
        out_valid_o = 1'b0;
      end
      pfb_pkg::ST_PAGE: begin
        out_valid_o = 1'b1;
        out_byte_o  = pfb_pkg::CMD_PAGE | {5'b0, cur_q.page};
        // Write back once, when the page byte leaves
        ram_we      = xfer;
        val_d       = xfer ? new_val : val_q;
      end
      pfb_pkg::ST_COLUMN: begin
        out_valid_o = 1'b1;
        out_byte_o  = pfb_pkg::CMD_COLUMN | {1'b0, cur_q.column};
      end
      pfb_pkg::ST_DATA: begin
        out_valid_o = 1'b1;
        out_byte_o  = val_q;
        is_data_o   = 1'b1;
        last_o      = 1'b1;
      end
      default: begin
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfb_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    val_q <= val_d;
  end

endmodule

// ----- hw/rtl/page_framebuffer_pixel_plotter.sv -----
// Channel  | Direction | Handshake              | Payload
// pixel in | input     | in_valid_i / in_ready_o | column_i[6:0], row_i[5:0], colour_i
// byte out | output    | out_valid_o / out_ready_i | out_byte_o[7:0], is_data_o, last_o
//
// Each on-panel pixel gives three output transfers: page command, column command,
// then the updated byte. Sustained rate is set by the three-byte output sequence of
// the back end: the next pixel leaves the queue as the data byte goes out, and its
// store read is issued then, so the byte is ready when the page command leaves.
// After reset the back end sweeps the shadow store to zero, one byte per cycle, over
// all ceil(PANEL_ROWS/8) * PANEL_COLUMNS bytes (504 at default size), input held off.
// A two-entry queue parts front and back, so pixels are taken while output stalls.
module page_framebuffer_pixel_plotter #(
  parameter int unsigned PANEL_COLUMNS = pfb_pkg::PanelColumnsDefault,
  parameter int unsigned PANEL_ROWS    = pfb_pkg::PanelRowsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [6:0] column_i,
  input  logic [5:0] row_i,
  input  logic       colour_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_data_o,
  output logic       last_o
);

  logic                 q_full;
  logic                 q_valid;
  logic                 push;
  logic                 pop;
  pfb_pkg::pfb_entry_t  push_entry;
  pfb_pkg::pfb_entry_t  q_head;
  pfb_pkg::pfb_status_t status;

  // Front: accept pixel transfers, drop off-panel ones, split row into page and bit
  pfb_front #(
    .PANEL_COLUMNS(PANEL_COLUMNS),
    .PANEL_ROWS   (PANEL_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .column_i    (column_i),
    .row_i       (row_i),
    .colour_i    (colour_i),
    .q_full_i    (q_full),
    .status_i    (status),
    .push_o      (push),
    .push_entry_o(push_entry)
  );

  // Queue: hold classified pixels until the back end is free
  pfb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Back: clear store, read-modify-write one byte, emit the three controller bytes
  pfb_back #(
    .PANEL_COLUMNS(PANEL_COLUMNS),
    .PANEL_ROWS   (PANEL_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .pop_o      (pop),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .is_data_o  (is_data_o),
    .last_o     (last_o)
  );

endmodule

// ----- hw/rtl/pfb_checker.sv -----
module pfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_data_o,
  input logic       last_o
);

  // A waiting pixel stays offered until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("pixel withdrawn before transfer");

  // A stalled output byte holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
                                    $stable(is_data_o) && $stable(last_o))
    else $error("output byte changed while stalled");

  // Only the data byte ends a run, and commands carry a command code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_data_o |-> !last_o && (out_byte_o[7] || out_byte_o[6]))
    else $error("bad command byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_data_o |-> last_o)
    else $error("data byte without last");

  // Page command is followed at once by the column command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !is_data_o && !out_byte_o[7]
      |=> out_valid_o && !is_data_o && out_byte_o[7])
    else $error("column command missing after page command");

endmodule

bind page_framebuffer_pixel_plotter pfb_checker u_pfb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_byte_o (out_byte_o),
  .is_data_o  (is_data_o),
  .last_o     (last_o)
);

// ----- tb/page_framebuffer_pixel_plotter_tb.sv -----
`timescale 1ns / 1ps

// One controller byte as it leaves the plotter.
typedef struct packed {
  logic [7:0] value;
  logic       is_data;
  logic       last;
} plot_byte_t;

// Shadow copy of the panel plus the controller bytes still owed by the block.
class plot_tracker;
  int unsigned cols;
  int unsigned rows;
  bit [7:0]    shadow[];
  plot_byte_t  owed_bytes[$];
  int          fails;

  function new();
    cols   = pfb_pkg::PanelColumnsDefault;
    rows   = pfb_pkg::PanelRowsDefault;
    shadow = new[((rows + 7) / 8) * cols];
    fails  = 0;
  endfunction

  task flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fails++;
  endtask

  // Apply one accepted pixel to the shadow copy and queue its three bytes.
  function void note_pixel(input logic [6:0] column, input logic [5:0] row,
                           input logic colour);
    int unsigned page;
    int unsigned slot;
    bit [7:0]    mask;
    bit [7:0]    value;
    if (column >= cols || row >= rows) return;
    page  = row >> 3;
    slot  = page * cols + column;
    mask  = 8'd1 << row[2:0];
    value = colour ? (shadow[slot] | mask) : (shadow[slot] & ~mask);
    shadow[slot] = value;
    owed_bytes.push_back('{pfb_pkg::CMD_PAGE | 8'(page), 1'b0, 1'b0});
    owed_bytes.push_back('{pfb_pkg::CMD_COLUMN | 8'(column), 1'b0, 1'b0});
    owed_bytes.push_back('{value, 1'b1, 1'b1});
  endfunction

  task check_byte(input logic [7:0] value, input logic is_data, input logic last);
    plot_byte_t want;
    if (owed_bytes.size() == 0) begin
      flag_mismatch($sformatf("unexpected byte %02h is_data=%0b last=%0b",
                              value, is_data, last));
      return;
    end
    want = owed_bytes.pop_front();
    if (value !== want.value)
      flag_mismatch($sformatf("out_byte %02h, want %02h", value, want.value));
    if (is_data !== want.is_data)
      flag_mismatch($sformatf("is_data %0b, want %0b on byte %02h",
                              is_data, want.is_data, want.value));
    if (last !== want.last)
      flag_mismatch($sformatf("last %0b, want %0b on byte %02h",
                              last, want.last, want.value));
  endtask
endclass

module page_framebuffer_pixel_plotter_tb;

  localparam int unsigned PanelCols  = pfb_pkg::PanelColumnsDefault;
  localparam int unsigned PanelRows  = pfb_pkg::PanelRowsDefault;
  // Generous: covers the clearing sweep plus a few hundred pixels at worst-case idling.
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldOff    = 400;
  localparam int unsigned DrainWait  = 20;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [6:0] column_i    = '0;
  logic [5:0] row_i       = '0;
  logic       colour_i    = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       is_data_o;
  logic       last_o;

  plot_tracker tracker = new();

  int unsigned cycles       = 0;
  int unsigned send_gap_pct = 0;  // chance per cycle that the sender sits idle
  int unsigned stall_pct    = 0;  // chance per cycle that the receiver stalls
  int unsigned hold_req     = 0;  // bump to ask the receiver for a long hold-off
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;

  page_framebuffer_pixel_plotter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .column_i   (column_i),
    .row_i      (row_i),
    .colour_i   (colour_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .is_data_o  (is_data_o),
    .last_o     (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off counted here so that the
  // pixel queue fills and the block drops in_ready_o.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldOff;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every byte transfer against the oldest owed byte. Values read here
  // are the ones from before the edge, as the block updates on the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_byte(out_byte_o, is_data_o, last_o);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still owed",
               cycles, tracker.owed_bytes.size());
      $display("** page_framebuffer_pixel_plotter: FAILED **");
      $finish;
    end
  end

  // Offer one pixel and hold it until the transfer. Random idle cycles come
  // first; valid is only lowered inside an idle gap, so back-to-back pixels
  // keep it high without a lower and raise in the same step.
  task send_pixel(input logic [6:0] column, input logic [5:0] row, input logic colour);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    column_i   <= column;
    row_i      <= row;
    colour_i   <= colour;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_pixel(column, row, colour);
  endtask

  // Mostly on-panel pixels; a share crowds a few columns so bytes build up
  // over several writes, and a share spans the whole field range as noise.
  task send_random_pixels(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    logic [6:0]  column;
    logic [5:0]  row;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        column = 7'($urandom_range(127));
        row    = 6'($urandom_range(63));
      end else if (pick < 45) begin
        column = 7'($urandom_range(1) ? $urandom_range(3) : $urandom_range(PanelCols - 1,
                                                                          PanelCols - 4));
        row    = 6'($urandom_range(PanelRows - 1));
      end else begin
        column = 7'($urandom_range(PanelCols - 1));
        row    = 6'($urandom_range(PanelRows - 1));
      end
      send_pixel(column, row, 1'($urandom_range(1)));
      sent++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: panel corners and edges, every off-panel boundary, all bits of
    // one byte, and repeated set and clear of the same pixel.
    send_pixel(7'd0, 6'd0, 1'b1);
    send_pixel(7'(PanelCols - 1), 6'(PanelRows - 1), 1'b1);
    send_pixel(7'(PanelCols - 1), 6'd0, 1'b1);
    send_pixel(7'd0, 6'(PanelRows - 1), 1'b1);
    send_pixel(7'(PanelCols), 6'd0, 1'b1);        // just past the right edge
    send_pixel(7'd0, 6'(PanelRows), 1'b1);        // just past the bottom edge
    send_pixel(7'd127, 6'd63, 1'b1);
    send_pixel(7'd127, 6'd0, 1'b0);
    send_pixel(7'd0, 6'd63, 1'b0);
    for (int r = 40; r < 48; r++) send_pixel(7'd64, 6'(r), 1'b1);
    send_pixel(7'd64, 6'd43, 1'b0);
    send_pixel(7'd0, 6'd0, 1'b0);
    send_pixel(7'd0, 6'd0, 1'b0);                 // clear an already clear pixel
    send_pixel(7'(PanelCols - 1), 6'(PanelRows - 1), 1'b1);  // set an already set one
    send_pixel(7'd42, 6'd21, 1'b1);

    // Phase 1: no idling, with one long receiver hold-off up front.
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_req     <= hold_req + 1;
    send_random_pixels(52);

    // Phase 2: sender idle half the time.
    send_gap_pct = 50;
    stall_pct    = 0;
    send_random_pixels(52);

    // Phase 3: receiver stalls half the time.
    send_gap_pct = 0;
    stall_pct    = 50;
    send_random_pixels(52);

    // Phase 4: light idling on both sides.
    send_gap_pct = 11;
    stall_pct    = 11;
    send_random_pixels(52);

    in_valid_i <= 1'b0;
    stall_pct  = 0;

    // Drain, then give stray bytes a chance to show up.
    while (tracker.owed_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (tracker.fails == 0) begin
      $display("** page_framebuffer_pixel_plotter: PASSED **");
    end else begin
      $display("** page_framebuffer_pixel_plotter: FAILED **");
    end
    $finish;
  end

endmodule
